/* rtl/core/sorted_expiry_timer_queue_defines.svh */
// Assertion macros shared by the timer queue checker.
`ifndef SORTED_EXPIRY_TIMER_QUEUE_DEFINES_SVH
`define SORTED_EXPIRY_TIMER_QUEUE_DEFINES_SVH
// Checks that an implication holds at every clock edge outside reset.
`define SETQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("timer queue check failed");
// Checks that an implication holds in the cycle after its antecedent.
`define SETQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("timer queue check failed");
`endif

/* rtl/core/setq_pkg.sv */
// Shared types and constants for the sorted expiry timer queue.
package setq_pkg;
    localparam int TIME_W = 63;
    localparam int SLOP_W = 30;
    localparam int ID_W = 4;
    localparam int MAX_FIRE = 16;
    localparam logic [SLOP_W-1:0] SLOP_RESET = SLOP_W'(50 * 1000);

    localparam logic [1:0] KIND_SET = 2'd0;
    localparam logic [1:0] KIND_STOP = 2'd1;
    localparam logic [1:0] KIND_EXPIRE = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   timer_id;
        logic [TIME_W-1:0] expiry_time;
        logic [TIME_W-1:0] current_time;
    } setq_in_t;

    typedef struct packed {
        logic [ID_W-1:0] fired_id;
        logic            last_fired;
    } setq_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the accepted item
        logic walk_start;  // start a list walk at the head
        logic walk_step;   // advance the walk one entry
        logic do_unlink;   // unlink at the walk position
        logic do_link;     // link in at the walk position
        logic do_pop;      // pop the head
    } setq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_active;   // named timer is queued
        logic id_ok;       // named timer exists
        logic empty;       // queue empty
        logic head_hit;    // head is the named timer
        logic head_after;  // head expiry is later than new time
        logic walk_done;   // walk reached the tail
        logic cur_hit;     // next entry is the named timer
        logic cur_after;   // next entry expires later than new time
        logic head_due;    // head expiry below threshold
    } setq_sts_t;
endpackage

/* rtl/core/setq_datapath.sv */
// Datapath of the timer queue: list storage, walk pointer and compares.
module setq_datapath import setq_pkg::*; #(
    parameter int NUM_TIMERS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  setq_in_t          in_item,
    input  logic [SLOP_W-1:0] slop,
    input  setq_cmd_t         cmd,
    output setq_sts_t         sts,
    output logic [ID_W-1:0]   head_id
);
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);

    logic [TIME_W-1:0] expiry_mem [NUM_TIMERS];
    logic [IW-1:0]     link_mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] active_reg;
    logic [IW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] exp_reg;
    logic [TIME_W:0]   limit_reg;
    logic [IW-1:0]     prev_reg;
    logic [CW-1:0]     n_reg;
    logic [IW-1:0]     id_idx;
    logic [IW-1:0]     cur;

    assign id_idx = IW'(id_reg);
    assign cur = link_mem[prev_reg];
    assign head_id = ID_W'(head_reg);

    // Status compares against the walk position and the head.
    always_comb begin
        sts.id_ok = ({{(32-ID_W){1'b0}}, id_reg} < 32'(NUM_TIMERS));
        sts.is_active = active_reg[id_idx];
        sts.empty = (count_reg == '0);
        sts.head_hit = (head_reg == id_idx);
        sts.head_after = (expiry_mem[head_reg] > exp_reg);
        sts.walk_done = (n_reg >= count_reg);
        sts.cur_hit = (cur == id_idx);
        sts.cur_after = (expiry_mem[cur] > exp_reg);
        sts.head_due = ({1'b0, expiry_mem[head_reg]} < limit_reg);
    end

    // List state updates driven by the controller's commands.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            head_reg <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.load) begin
                id_reg <= in_item.timer_id;
                exp_reg <= in_item.expiry_time;
                limit_reg <= {1'b0, in_item.current_time} + (TIME_W + 1)'(slop);
            end
            if (cmd.walk_start) begin
                prev_reg <= head_reg;
                n_reg <= CW'(1);
            end
            if (cmd.walk_step) begin
                prev_reg <= cur;
                n_reg <= n_reg + CW'(1);
            end
            if (cmd.do_unlink) begin
                if (sts.head_hit) begin
                    head_reg <= link_mem[id_idx];
                end else begin
                    link_mem[prev_reg] <= link_mem[id_idx];
                end
                count_reg <= count_reg - CW'(1);
                active_reg[id_idx] <= 1'b0;
            end
            if (cmd.do_link) begin
                expiry_mem[id_idx] <= exp_reg;
                if (sts.empty || sts.head_after) begin
                    link_mem[id_idx] <= head_reg;
                    head_reg <= id_idx;
                end else begin
                    link_mem[id_idx] <= cur;
                    link_mem[prev_reg] <= id_idx;
                end
                count_reg <= count_reg + CW'(1);
                active_reg[id_idx] <= 1'b1;
            end
            if (cmd.do_pop) begin
                head_reg <= link_mem[head_reg];
                count_reg <= count_reg - CW'(1);
                active_reg[head_reg] <= 1'b0;
            end
        end
    end
endmodule

/* rtl/core/setq_ctrl.sv */
// Controller state machine of the timer queue.
module setq_ctrl import setq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  setq_sts_t  sts,
    output setq_cmd_t  cmd,
    output logic       out_load,
    input  logic       out_free
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_DECODE, ST_UNWALK, ST_LINK, ST_LWALK, ST_FIRE
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] kind_reg, kind_next;
    logic [4:0] fired_reg, fired_next;
    logic linked;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        kind_next = kind_reg;
        fired_next = fired_reg;
        cmd = '0;
        out_load = 1'b0;
        linked = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    kind_next = s_kind;
                    fired_next = '0;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (kind_reg == KIND_EXPIRE) begin
                    state_next = ST_FIRE;
                end else if ((kind_reg == KIND_SET || kind_reg == KIND_STOP) && sts.id_ok) begin
                    if (sts.is_active) begin
                        if (sts.head_hit) begin
                            cmd.do_unlink = 1'b1;
                            state_next = (kind_reg == KIND_SET) ? ST_LINK : ST_IDLE;
                        end else begin
                            cmd.walk_start = 1'b1;
                            state_next = ST_UNWALK;
                        end
                    end else begin
                        state_next = (kind_reg == KIND_SET) ? ST_LINK : ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_UNWALK: begin
                // One entry per cycle until the successor is the named timer or the walk reaches the tail.
                if (sts.cur_hit) begin
                    cmd.do_unlink = 1'b1;
                    state_next = (kind_reg == KIND_SET) ? ST_LINK : ST_IDLE;
                end else if (sts.walk_done) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_LINK: begin
                if (sts.empty || sts.head_after) begin
                    cmd.do_link = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.walk_start = 1'b1;
                    state_next = ST_LWALK;
                end
            end
            ST_LWALK: begin
                linked = sts.walk_done || sts.cur_after;
                if (linked) begin
                    cmd.do_link = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_FIRE: begin
                // Pop one due head per cycle when the output slot is free.
                // The check ends only when the slot can take the last result.
                if (sts.empty || !sts.head_due || fired_reg == 5'(MAX_FIRE)) begin
                    if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end else if (out_free) begin
                    cmd.do_pop = 1'b1;
                    out_load = 1'b1;
                    fired_next = fired_reg + 5'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg <= '0;
            fired_reg <= '0;
        end else begin
            state_reg <= state_next;
            kind_reg <= kind_next;
            fired_reg <= fired_next;
        end
    end
endmodule

/* rtl/core/sorted_expiry_timer_queue.sv */
// Sorted expiry timer queue: a set or stop item keeps the block busy from acceptance to
// the next acceptance while its list walks run, which visit one entry per cycle.
// An expire item pops its due timers one at a time and also waits on result channel stalls;
// results wait in a one-item output buffer, with last_fired marked as the following
// head is checked. Items are taken one at a time.
// Reset (synchronous, active low) empties the queue and restores slop to 50000.
module sorted_expiry_timer_queue import setq_pkg::*; #(
    parameter int NUM_TIMERS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  setq_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output setq_out_t         m_data,
    input  logic              cfg_we,
    input  logic [SLOP_W-1:0] cfg_wdata
);
    setq_cmd_t cmd;
    setq_sts_t sts;
    logic [ID_W-1:0] head_id;
    logic [SLOP_W-1:0] slop_reg;
    logic out_load, out_free;
    logic pend_reg;
    logic [ID_W-1:0] pend_id_reg;
    logic fire_state;
    logic pend_send;

    // Slop window register.
    always_ff @(posedge aclk) begin
        if (!aresetn) slop_reg <= SLOP_RESET;
        else if (cfg_we) slop_reg <= cfg_wdata;
    end

    setq_datapath #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_item(s_data), .slop(slop_reg),
        .cmd(cmd), .sts(sts), .head_id(head_id)
    );

    setq_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_kind(s_data.kind), .sts(sts), .cmd(cmd), .out_load(out_load),
        .out_free(out_free)
    );

    // A popped id is held pending until the next head is known, which
    // decides its last marker; then it moves to the output register.
    assign fire_state = !s_ready && !out_load;
    assign out_free = !m_valid || m_ready;
    assign pend_send = pend_reg && (out_load || (fire_state && out_free));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            m_valid <= 1'b0;
        end else begin
            if (out_load) begin
                pend_id_reg <= head_id;
                pend_reg <= 1'b1;
            end else if (pend_send) begin
                pend_reg <= 1'b0;
            end
            if (pend_send) begin
                m_valid <= 1'b1;
                m_data.fired_id <= pend_id_reg;
                m_data.last_fired <= !out_load;
            end else if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end
endmodule

/* rtl/core/setq_checker.sv */
// Port-level checker for the timer queue, bound to the top level.
`include "sorted_expiry_timer_queue_defines.svh"
module setq_checker import setq_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input setq_out_t m_data
);
    // A result waiting on a stalled output holds its item.
    `SETQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // After an item is taken the block is busy in the cycle after.
    `SETQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // No result is shown while the block is idle and no result is pending.
    `SETQ_ASSERT_IMP(a_idle_no_new, aclk, aresetn, $rose(m_valid), !$past(s_ready) || !s_ready)
endmodule

bind sorted_expiry_timer_queue setq_checker u_setq_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
